FILE: design/lph_pkg.sv
package lph_pkg;

    localparam int CAPACITY_DEF = 1024;

    localparam int          MAX_W             = 10;
    localparam int          COUNT_W           = 11;
    localparam logic [9:0]  MAX_ENTRIES_RESET = 10'd512;

    localparam logic [1:0] OP_PUT    = 2'd0;
    localparam logic [1:0] OP_GET    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_LIVE  = 2'd1;
    localparam logic [1:0] MARK_TOMB  = 2'd2;

    localparam logic [63:0] HASH_C1 = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] HASH_C2 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] HASH_C3 = 64'h94d049bb133111eb;
    localparam int          HASH_S1 = 30;
    localparam int          HASH_S2 = 27;
    localparam int          HASH_S3 = 31;

endpackage

FILE: design/lph_hash.sv
module lph_hash
    import lph_pkg::*;
#(
    parameter int IDX_W = 10
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [63:0]      lo,
    input  logic [63:0]      hi,
    output logic             done,
    output logic [IDX_W-1:0] slot
);

    // three 64-bit multiplies, each as three 32x32 partial products
    localparam logic [1:0] PH_0 = 2'd0;
    localparam logic [1:0] PH_1 = 2'd1;
    localparam logic [1:0] PH_2 = 2'd2;

    logic        busy_reg;
    logic        done_reg;
    logic [1:0]  phase_reg;
    logic [1:0]  sub_reg;
    logic [63:0] lo_reg;
    logic [63:0] hi_reg;
    logic [63:0] x_reg;
    logic [63:0] x_next;
    logic [63:0] acc_reg;
    logic [63:0] prod_reg;
    logic [63:0] op_a;
    logic [63:0] op_b;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod_w;
    logic [63:0] res_w;
    logic [63:0] t_w;

    assign op_a = (phase_reg == PH_0) ? hi_reg : x_reg;

    always_comb
    begin
        unique case (phase_reg)
            PH_0:    op_b = HASH_C1;
            PH_1:    op_b = HASH_C2;
            default: op_b = HASH_C3;
        endcase
    end

    always_comb
    begin
        unique case (sub_reg)
            2'd0:
            begin
                mul_a = op_a[31:0];
                mul_b = op_b[31:0];
            end
            2'd1:
            begin
                mul_a = op_a[31:0];
                mul_b = op_b[63:32];
            end
            default:
            begin
                mul_a = op_a[63:32];
                mul_b = op_b[31:0];
            end
        endcase
    end

    assign prod_w = 64'(mul_a) * 64'(mul_b);
    assign res_w  = acc_reg + {prod_reg[31:0], 32'd0};
    assign t_w    = lo_reg ^ res_w;

    always_comb
    begin
        unique case (phase_reg)
            PH_0:    x_next = t_w ^ (t_w >> HASH_S1);
            PH_1:    x_next = res_w ^ (res_w >> HASH_S2);
            default: x_next = res_w ^ (res_w >> HASH_S3);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= PH_0;
            sub_reg   <= 2'd0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (sub_reg == 2'd3) && (phase_reg == PH_2);
            if (start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= PH_0;
                sub_reg   <= 2'd0;
            end
            else if (busy_reg)
            begin
                sub_reg <= sub_reg + 2'd1;
                if (sub_reg == 2'd3)
                begin
                    if (phase_reg == PH_2)
                    begin
                        busy_reg <= 1'b0;
                    end
                    else
                    begin
                        phase_reg <= phase_reg + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            lo_reg <= lo;
            hi_reg <= hi;
        end
        else if (busy_reg)
        begin
            prod_reg <= prod_w;
            if (sub_reg == 2'd1)
                acc_reg <= prod_reg;
            else if (sub_reg == 2'd2)
                acc_reg <= res_w;
            if (sub_reg == 2'd3)
                x_reg <= x_next;
        end
    end

    assign done = done_reg;
    assign slot = x_reg[IDX_W-1:0];

endmodule

FILE: design/linear_probe_hash_table_unit.sv
// Linear-probing hash table, 128-bit keys, 64-bit values, with tombstones.
// Input channel: in_valid/in_stall carry operation, key_low, key_high and
// new_value; a transfer happens when in_valid is high and in_stall low.
// Output channel: out_valid/out_stall carry status and found_value, one
// result per input transfer, in order.
// cfg_we/cfg_wdata set max_entries (reset 512); write only when idle.
// Put/get/remove: the key is hashed (one shared 32x32 multiplier,
// three partial products per 64-bit multiply), then each probe reads
// the registered-read slot memories (S_RD) and checks the slot (S_CHK),
// then S_END loads and updates and S_RESP hands over to the output.
// Clear sweeps the mark memory one slot a cycle.
// One item is worked on at a time; in_stall is high while busy.
// After reset the same sweep runs with in_stall high.
// A result waits in the output register while out_stall is high; a new
// item may be taken meanwhile, but its result holds until the register
// frees. CAPACITY must be a power of two.
module linear_probe_hash_table_unit
    import lph_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        operation,
    input  logic [63:0]       key_low,
    input  logic [63:0]       key_high,
    input  logic [63:0]       new_value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [63:0]       found_value,
    input  logic              cfg_we,
    input  logic [MAX_W-1:0]  cfg_wdata
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_HASH = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_CHK  = 3'd4;
    localparam logic [2:0] S_END  = 3'd5;
    localparam logic [2:0] S_RESP = 3'd6;

    // slot memories
    logic [127:0] key_mem  [CAPACITY];
    logic [63:0]  val_mem  [CAPACITY];
    logic [1:0]   mark_mem [CAPACITY];

    logic [127:0] key_rd_reg;
    logic [63:0]  val_rd_reg;
    logic [1:0]   mark_rd_reg;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [IDX_W-1:0]   clr_cnt_reg;
    logic               clr_op_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [MAX_W-1:0]   max_reg;

    logic [1:0]         op_reg;
    logic [127:0]       key_reg;
    logic [63:0]        new_val_reg;

    logic [IDX_W-1:0]   p_reg;
    logic [IDX_W-1:0]   n_reg;
    logic               hit_reg;
    logic               free_ok_reg;
    logic [IDX_W-1:0]   free_reg;

    logic [1:0]         res_status_reg;
    logic [63:0]        res_found_reg;
    logic               out_valid_reg;
    logic [1:0]         status_reg;
    logic [63:0]        found_reg;

    logic               in_xfer;
    logic               out_free;
    logic               hash_start;
    logic               hash_done;
    logic [IDX_W-1:0]   hash_slot;
    logic               over_limit;

    // memory write port controls
    logic               mark_we;
    logic [IDX_W-1:0]   mark_waddr;
    logic [1:0]         mark_wdata;
    logic               kv_we;
    logic               key_we;
    logic [IDX_W-1:0]   kv_waddr;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_xfer    = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign hash_start = in_xfer && (operation != OP_CLEAR);
    assign over_limit = (count_reg + COUNT_W'(1)) > COUNT_W'(max_reg);

    lph_hash #(
        .IDX_W (IDX_W)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .lo    (key_low),
        .hi    (key_high),
        .done  (hash_done),
        .slot  (hash_slot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:
                if (clr_cnt_reg == LAST_IDX)
                    state_next = clr_op_reg ? S_RESP : S_IDLE;
            S_IDLE:
                if (in_xfer)
                    state_next = (operation == OP_CLEAR) ? S_CLR : S_HASH;
            S_HASH:
                if (hash_done)
                    state_next = S_RD;
            S_RD:
                state_next = S_CHK;
            S_CHK:
                if (mark_rd_reg == MARK_EMPTY)
                    state_next = S_END;
                else if (mark_rd_reg == MARK_LIVE && key_rd_reg == key_reg)
                    state_next = S_END;
                else if (n_reg == LAST_IDX)
                    state_next = S_END;
                else
                    state_next = S_RD;
            S_END:
                state_next = S_RESP;
            S_RESP:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // write port selection: clear sweep, value update, tombstone, or insert
    always_comb
    begin
        mark_we    = 1'b0;
        mark_waddr = clr_cnt_reg;
        mark_wdata = MARK_EMPTY;
        kv_we      = 1'b0;
        key_we     = 1'b0;
        kv_waddr   = p_reg;
        if (state_reg == S_CLR)
        begin
            mark_we = 1'b1;
        end
        else if (state_reg == S_END)
        begin
            priority case (1'b1)
                (op_reg == OP_PUT) && hit_reg:
                begin
                    kv_we = 1'b1;
                end
                (op_reg == OP_PUT) && !over_limit && free_ok_reg:
                begin
                    kv_we      = 1'b1;
                    key_we     = 1'b1;
                    kv_waddr   = free_reg;
                    mark_we    = 1'b1;
                    mark_waddr = free_reg;
                    mark_wdata = MARK_LIVE;
                end
                (op_reg == OP_REMOVE) && hit_reg:
                begin
                    mark_we    = 1'b1;
                    mark_waddr = p_reg;
                    mark_wdata = MARK_TOMB;
                end
                default:
                begin
                    mark_we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
            mark_mem[mark_waddr] <= mark_wdata;
        if (state_reg == S_RD)
            mark_rd_reg <= mark_mem[p_reg];
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[kv_waddr] <= key_reg;
        if (state_reg == S_RD)
            key_rd_reg <= key_mem[p_reg];
    end

    always_ff @(posedge clk)
    begin
        if (kv_we)
            val_mem[kv_waddr] <= new_val_reg;
        if (state_reg == S_RD)
            val_rd_reg <= val_mem[p_reg];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_cnt_reg   <= '0;
            clr_op_reg    <= 1'b0;
            count_reg     <= '0;
            max_reg       <= MAX_ENTRIES_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                max_reg <= cfg_wdata;
            if (state_reg == S_CLR)
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            if (in_xfer && operation == OP_CLEAR)
            begin
                clr_op_reg  <= 1'b1;
                clr_cnt_reg <= '0;
                count_reg   <= '0;
            end
            if (state_reg == S_END)
            begin
                if (op_reg == OP_PUT && !hit_reg && !over_limit && free_ok_reg)
                    count_reg <= count_reg + COUNT_W'(1);
                else if (op_reg == OP_REMOVE && hit_reg && count_reg != '0)
                    count_reg <= count_reg - COUNT_W'(1);
            end
            if (state_reg == S_RESP && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload and probe walk
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg      <= operation;
            key_reg     <= {key_high, key_low};
            new_val_reg <= new_value;
        end
        if (hash_done)
        begin
            p_reg       <= hash_slot;
            n_reg       <= '0;
            hit_reg     <= 1'b0;
            free_ok_reg <= 1'b0;
        end
        if (state_reg == S_CHK)
        begin
            if (mark_rd_reg == MARK_EMPTY)
            begin
                if (!free_ok_reg)
                begin
                    free_ok_reg <= 1'b1;
                    free_reg    <= p_reg;
                end
            end
            else if (mark_rd_reg == MARK_LIVE && key_rd_reg == key_reg)
            begin
                hit_reg <= 1'b1;
            end
            else
            begin
                // tombstone: first one is the insert candidate
                if (mark_rd_reg != MARK_LIVE && !free_ok_reg)
                begin
                    free_ok_reg <= 1'b1;
                    free_reg    <= p_reg;
                end
                if (n_reg != LAST_IDX)
                begin
                    n_reg <= n_reg + IDX_W'(1);
                    p_reg <= p_reg + IDX_W'(1);
                end
            end
        end
        if (state_reg == S_CLR)
        begin
            res_status_reg <= ST_OK;
            res_found_reg  <= '0;
        end
        if (state_reg == S_END)
        begin
            unique case (op_reg)
                OP_PUT:
                begin
                    res_found_reg  <= '0;
                    res_status_reg <= (!hit_reg && (over_limit || !free_ok_reg)) ?
                                      ST_FULL : ST_OK;
                end
                OP_GET, OP_REMOVE:
                begin
                    res_found_reg  <= hit_reg ? val_rd_reg : '0;
                    res_status_reg <= hit_reg ? ST_OK : ST_MISS;
                end
                default:
                begin
                    res_found_reg  <= '0;
                    res_status_reg <= ST_OK;
                end
            endcase
        end
        if (state_reg == S_RESP && out_free)
        begin
            status_reg <= res_status_reg;
            found_reg  <= res_found_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found_value = found_reg;

    // checks
    a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("result raised outside response step");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg != S_IDLE))
        else $error("still idle after input transfer");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[COUNT_W-1] == 1'b0)
        else $error("live count out of range");

    a_hash_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        hash_done |-> (state_reg == S_HASH))
        else $error("hash finished outside hash step");

endmodule
